@@ rtl/hsvc_pkg.sv @@
`default_nettype none
package hsvc_pkg;

  localparam int HUE_W  = 9;
  localparam int FRAC_W = 9;
  localparam int CH_W   = 8;
  localparam int SECT_W = 4;   // hue div 60 reaches 8 for a 9-bit hue
  localparam int REM_W  = 6;
  localparam int COEF_W = 14;  // numerators before the value multiply, max 15360
  localparam int NUM_W  = 22;  // full numerators, max 256 * 15360

  localparam int SEG_DEG   = 60;
  localparam int FRAC_ONE  = 256;
  localparam int FULL_COEF = FRAC_ONE * SEG_DEG;  // 1.0 in the coefficient scale

  // hue * RECIP >> RECIP_SH gives hue div 60 exactly for every 9-bit hue
  localparam int RECIP    = 1093;
  localparam int RECIP_SH = 16;
  localparam int RPROD_W  = HUE_W + 11;

  // 255 / (256 * 256 * 60) = 17 / 2^18
  localparam int CH_MUL   = 17;
  localparam int CH_SH    = 18;
  localparam int CHPROD_W = NUM_W + 5;

  localparam logic [SECT_W-1:0] SECT_RED_YEL   = 4'd0;
  localparam logic [SECT_W-1:0] SECT_YEL_GRN   = 4'd1;
  localparam logic [SECT_W-1:0] SECT_GRN_CYN   = 4'd2;
  localparam logic [SECT_W-1:0] SECT_CYN_BLU   = 4'd3;
  localparam logic [SECT_W-1:0] SECT_BLU_MAG   = 4'd4;
  localparam logic [SECT_W-1:0] SECT_LAST      = 4'd8;

  typedef struct packed {
    logic [SECT_W-1:0] sector;
    logic [REM_W-1:0]  rem;
    logic [FRAC_W-1:0] sat;
    logic [FRAC_W-1:0] val;
  } split_t;

  typedef struct packed {
    logic [SECT_W-1:0] sector;
    logic [FRAC_W-1:0] val;
    logic [COEF_W-1:0] cp;
    logic [COEF_W-1:0] cq;
    logic [COEF_W-1:0] ct;
  } coef_t;

  typedef struct packed {
    logic [SECT_W-1:0] sector;
    logic [NUM_W-1:0]  nv;
    logic [NUM_W-1:0]  np;
    logic [NUM_W-1:0]  nq;
    logic [NUM_W-1:0]  nt;
  } num_t;

endpackage
`default_nettype wire

@@ rtl/hsvc_if.sv @@
`default_nettype none
interface hsvc_in_if;
  logic                       valid;
  logic                       ready;
  logic [hsvc_pkg::HUE_W-1:0]  hue_deg;
  logic [hsvc_pkg::FRAC_W-1:0] sat_frac;
  logic [hsvc_pkg::FRAC_W-1:0] val_frac;

  modport source (output valid, output hue_deg, output sat_frac, output val_frac,
                  input ready);
  modport sink   (input valid, input hue_deg, input sat_frac, input val_frac,
                  output ready);
endinterface

interface hsvc_out_if;
  logic                      valid;
  logic                      ready;
  logic [hsvc_pkg::CH_W-1:0] red_out;
  logic [hsvc_pkg::CH_W-1:0] green_out;
  logic [hsvc_pkg::CH_W-1:0] blue_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/hsv_to_rgb_converter.sv @@
// Throughput: one transaction per cycle while the output accepts; four registered
// stages (sector split, coefficients, value multiply, channel select and scale),
// each with its own valid.
// A stalled stage holds its contents; bubbles are squeezed out behind it.
// Reset (rst_n low, synchronous) clears all stage valids; payload is not reset.
`default_nettype none
module hsv_to_rgb_converter (
  input  wire logic   clk,
  input  wire logic   rst_n,
  hsvc_in_if.sink     in_chan,
  hsvc_out_if.source  out_chan
);

  logic             s1_valid;
  logic             s1_ready;
  hsvc_pkg::split_t s1_data;
  logic             s2_valid;
  logic             s2_ready;
  hsvc_pkg::coef_t  s2_data;
  logic             s3_valid;
  logic             s3_ready;
  hsvc_pkg::num_t   s3_data;
  logic             s4_ready;

  hsvc_split u_split (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_chan.valid),
    .ready_o (s1_ready),
    .hue_i   (in_chan.hue_deg),
    .sat_i   (in_chan.sat_frac),
    .val_i   (in_chan.val_frac),
    .valid_r (s1_valid),
    .ready_i (s2_ready),
    .data_r  (s1_data)
  );

  assign in_chan.ready = s1_ready;

  hsvc_coef u_coef (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s1_valid),
    .ready_o (s2_ready),
    .data_i  (s1_data),
    .valid_r (s2_valid),
    .ready_i (s3_ready),
    .data_r  (s2_data)
  );

  hsvc_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s2_valid),
    .ready_o (s3_ready),
    .data_i  (s2_data),
    .valid_r (s3_valid),
    .ready_i (s4_ready),
    .data_r  (s3_data)
  );

  hsvc_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (s3_valid),
    .ready_o  (s4_ready),
    .data_i   (s3_data),
    .out_chan (out_chan)
  );

  // an accepted transaction always lands in the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> s1_valid)
    else $error("accepted transaction missing from first stage");

  // reciprocal split must give a sector within range and a remainder below 60
  a_split: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid |-> (s1_data.sector <= hsvc_pkg::SECT_LAST) &&
                 (s1_data.rem < hsvc_pkg::REM_W'(hsvc_pkg::SEG_DEG)))
    else $error("hue split out of range");

  // a stage blocked from below keeps its transaction
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid && !s3_ready |=> s2_valid && $stable(s2_data))
    else $error("stalled coefficient stage lost its transaction");

  // the value numerator never exceeds full scale
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid |-> s3_data.nv <= hsvc_pkg::NUM_W'(hsvc_pkg::FRAC_ONE * hsvc_pkg::FULL_COEF))
    else $error("value numerator above full scale");

endmodule
`default_nettype wire

@@ rtl/hsvc_split.sv @@
`default_nettype none
module hsvc_split (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       valid_i,
  output logic                            ready_o,
  input  wire logic [hsvc_pkg::HUE_W-1:0]  hue_i,
  input  wire logic [hsvc_pkg::FRAC_W-1:0] sat_i,
  input  wire logic [hsvc_pkg::FRAC_W-1:0] val_i,
  output logic                            valid_r,
  input  wire logic                       ready_i,
  output hsvc_pkg::split_t                data_r
);

  logic [hsvc_pkg::RPROD_W-1:0] rprod;
  logic [hsvc_pkg::HUE_W-1:0]   base;
  logic [hsvc_pkg::HUE_W-1:0]   diff;
  hsvc_pkg::split_t             data_nxt;

  always_comb begin
    rprod = hsvc_pkg::RPROD_W'(hue_i) * hsvc_pkg::RPROD_W'(hsvc_pkg::RECIP);
    data_nxt.sector = rprod[hsvc_pkg::RECIP_SH +: hsvc_pkg::SECT_W];
    base = hsvc_pkg::HUE_W'(data_nxt.sector) * hsvc_pkg::HUE_W'(hsvc_pkg::SEG_DEG);
    diff = hue_i - base;
    data_nxt.rem = diff[hsvc_pkg::REM_W-1:0];
    data_nxt.sat = (sat_i > hsvc_pkg::FRAC_W'(hsvc_pkg::FRAC_ONE)) ?
                   hsvc_pkg::FRAC_W'(hsvc_pkg::FRAC_ONE) : sat_i;
    data_nxt.val = (val_i > hsvc_pkg::FRAC_W'(hsvc_pkg::FRAC_ONE)) ?
                   hsvc_pkg::FRAC_W'(hsvc_pkg::FRAC_ONE) : val_i;
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      data_r <= data_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/hsvc_coef.sv @@
`default_nettype none
module hsvc_coef (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire hsvc_pkg::split_t data_i,
  output logic                  valid_r,
  input  wire logic             ready_i,
  output hsvc_pkg::coef_t       data_r
);

  localparam int W = hsvc_pkg::COEF_W + 2;

  logic [W-1:0]    one_minus_s;
  logic [W-1:0]    s_rem;
  logic [W-1:0]    s_rem_inv;
  logic [W-1:0]    prod_p;
  logic [W-1:0]    diff_q;
  logic [W-1:0]    diff_t;
  hsvc_pkg::coef_t data_nxt;

  always_comb begin
    one_minus_s = W'(hsvc_pkg::FRAC_ONE) - W'(data_i.sat);
    s_rem       = W'(data_i.sat) * W'(data_i.rem);
    s_rem_inv   = W'(data_i.sat) * (W'(hsvc_pkg::SEG_DEG) - W'(data_i.rem));
    prod_p      = one_minus_s * W'(hsvc_pkg::SEG_DEG);
    diff_q      = W'(hsvc_pkg::FULL_COEF) - s_rem;
    diff_t      = W'(hsvc_pkg::FULL_COEF) - s_rem_inv;
    data_nxt.sector = data_i.sector;
    data_nxt.val    = data_i.val;
    data_nxt.cp     = prod_p[hsvc_pkg::COEF_W-1:0];
    data_nxt.cq     = diff_q[hsvc_pkg::COEF_W-1:0];
    data_nxt.ct     = diff_t[hsvc_pkg::COEF_W-1:0];
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      data_r <= data_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/hsvc_scale.sv @@
`default_nettype none
module hsvc_scale (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire hsvc_pkg::coef_t data_i,
  output logic                 valid_r,
  input  wire logic            ready_i,
  output hsvc_pkg::num_t       data_r
);

  localparam int NW = hsvc_pkg::NUM_W;

  hsvc_pkg::num_t data_nxt;

  // four narrow multiplies by the value, in parallel
  always_comb begin
    data_nxt.sector = data_i.sector;
    data_nxt.nv = NW'(data_i.val) * NW'(hsvc_pkg::FULL_COEF);
    data_nxt.np = NW'(data_i.val) * NW'(data_i.cp);
    data_nxt.nq = NW'(data_i.val) * NW'(data_i.cq);
    data_nxt.nt = NW'(data_i.val) * NW'(data_i.ct);
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      data_r <= data_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/hsvc_mix.sv @@
`default_nettype none
module hsvc_mix (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                valid_i,
  output logic                     ready_o,
  input  wire hsvc_pkg::num_t      data_i,
  hsvc_out_if.source               out_chan
);

  localparam int PW = hsvc_pkg::CHPROD_W;

  logic [hsvc_pkg::NUM_W-1:0] r_num;
  logic [hsvc_pkg::NUM_W-1:0] g_num;
  logic [hsvc_pkg::NUM_W-1:0] b_num;
  logic [PW-1:0]              r_prod;
  logic [PW-1:0]              g_prod;
  logic [PW-1:0]              b_prod;
  logic                       valid_r;
  logic [hsvc_pkg::CH_W-1:0]  red_r;
  logic [hsvc_pkg::CH_W-1:0]  green_r;
  logic [hsvc_pkg::CH_W-1:0]  blue_r;

  always_comb begin
    unique case (data_i.sector)
      hsvc_pkg::SECT_RED_YEL: begin
        r_num = data_i.nv; g_num = data_i.nt; b_num = data_i.np;
      end
      hsvc_pkg::SECT_YEL_GRN: begin
        r_num = data_i.nq; g_num = data_i.nv; b_num = data_i.np;
      end
      hsvc_pkg::SECT_GRN_CYN: begin
        r_num = data_i.np; g_num = data_i.nv; b_num = data_i.nt;
      end
      hsvc_pkg::SECT_CYN_BLU: begin
        r_num = data_i.np; g_num = data_i.nq; b_num = data_i.nv;
      end
      hsvc_pkg::SECT_BLU_MAG: begin
        r_num = data_i.nt; g_num = data_i.np; b_num = data_i.nv;
      end
      // last sector, and hues past 359
      default: begin
        r_num = data_i.nv; g_num = data_i.np; b_num = data_i.nq;
      end
    endcase
    r_prod = PW'(r_num) * PW'(hsvc_pkg::CH_MUL);
    g_prod = PW'(g_num) * PW'(hsvc_pkg::CH_MUL);
    b_prod = PW'(b_num) * PW'(hsvc_pkg::CH_MUL);
  end

  assign ready_o = !valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      red_r   <= r_prod[hsvc_pkg::CH_SH +: hsvc_pkg::CH_W];
      green_r <= g_prod[hsvc_pkg::CH_SH +: hsvc_pkg::CH_W];
      blue_r  <= b_prod[hsvc_pkg::CH_SH +: hsvc_pkg::CH_W];
    end
  end

  assign out_chan.valid     = valid_r;
  assign out_chan.red_out   = red_r;
  assign out_chan.green_out = green_r;
  assign out_chan.blue_out  = blue_r;

endmodule
`default_nettype wire

@@ tb/sv/tb_hsv_to_rgb_converter.sv @@
`timescale 1ns / 1ps
module tb_hsv_to_rgb_converter;
  import hsvc_pkg::*;

  localparam longint unsigned RGB_DEN = FRAC_ONE * FULL_COEF;  // 256 * 256 * 60
  localparam int CH_MAX      = 255;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam int N_DIRECTED  = 25;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [FRAC_W-1:0] sat;
    logic [FRAC_W-1:0] val;
    logic              known;
    rgb_t              rgb;
  } hsv_row_t;

  logic clk;
  logic rst_n;

  hsvc_in_if  in_bus ();
  hsvc_out_if out_bus ();

  hsv_to_rgb_converter uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  rgb_t pending_rgb[$];
  int   mismatch_count;
  bit   idle_on;
  bit   hold_req;

  // hue, sat, val, known, {r, g, b}; unknown rows go through the colour predictor
  hsv_row_t directed_rows [0:N_DIRECTED-1] = '{
    '{9'd0,   9'd0,   9'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{9'd0,   9'd0,   9'd256, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{9'd0,   9'd256, 9'd256, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{9'd60,  9'd256, 9'd256, 1'b1, '{8'd255, 8'd255, 8'd0}},
    '{9'd120, 9'd256, 9'd256, 1'b1, '{8'd0,   8'd255, 8'd0}},
    '{9'd180, 9'd256, 9'd256, 1'b1, '{8'd0,   8'd255, 8'd255}},
    '{9'd240, 9'd256, 9'd256, 1'b1, '{8'd0,   8'd0,   8'd255}},
    '{9'd300, 9'd256, 9'd256, 1'b1, '{8'd255, 8'd0,   8'd255}},
    '{9'd511, 9'd511, 9'd511, 1'b1, '{8'd255, 8'd0,   8'd123}},
    '{9'd100, 9'd0,   9'd511, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{9'd0,   9'd257, 9'd256, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{9'd30,  9'd128, 9'd200, 1'b0, '0},
    '{9'd90,  9'd200, 9'd100, 1'b0, '0},
    '{9'd150, 9'd77,  9'd256, 1'b0, '0},
    '{9'd210, 9'd256, 9'd128, 1'b0, '0},
    '{9'd270, 9'd1,   9'd255, 1'b0, '0},
    '{9'd330, 9'd128, 9'd128, 1'b0, '0},
    '{9'd359, 9'd256, 9'd256, 1'b0, '0},
    '{9'd59,  9'd256, 9'd256, 1'b0, '0},
    '{9'd360, 9'd200, 9'd200, 1'b0, '0},
    '{9'd420, 9'd100, 9'd256, 1'b0, '0},
    '{9'd479, 9'd256, 9'd1,   1'b0, '0},
    '{9'd480, 9'd300, 9'd180, 1'b0, '0},
    '{9'd1,   9'd1,   9'd1,   1'b0, '0},
    '{9'd256, 9'd255, 9'd255, 1'b0, '0}
  };

  function automatic rgb_t hsv_to_rgb_expected(input logic [HUE_W-1:0] hue,
                                               input logic [FRAC_W-1:0] sat,
                                               input logic [FRAC_W-1:0] val);
    longint unsigned s, v, rem, nv, np, nq, nt, r, g, b;
    logic [SECT_W-1:0] sector;
    rgb_t res;
    s = (sat > FRAC_ONE) ? FRAC_ONE : sat;
    v = (val > FRAC_ONE) ? FRAC_ONE : val;
    sector = SECT_W'(hue / SEG_DEG);
    rem = hue % SEG_DEG;
    nv = v * FULL_COEF;
    np = v * (FRAC_ONE - s) * SEG_DEG;
    nq = v * (FULL_COEF - s * rem);
    nt = v * (FULL_COEF - s * (SEG_DEG - rem));
    case (sector)
      SECT_RED_YEL: begin r = nv; g = nt; b = np; end
      SECT_YEL_GRN: begin r = nq; g = nv; b = np; end
      SECT_GRN_CYN: begin r = np; g = nv; b = nt; end
      SECT_CYN_BLU: begin r = np; g = nq; b = nv; end
      SECT_BLU_MAG: begin r = nt; g = np; b = nv; end
      // sector 5 and every hue past 359 share the magenta-red assignment
      default: begin r = nv; g = np; b = nq; end
    endcase
    res.red   = CH_W'((r * CH_MAX) / RGB_DEN);
    res.green = CH_W'((g * CH_MAX) / RGB_DEN);
    res.blue  = CH_W'((b * CH_MAX) / RGB_DEN);
    return res;
  endfunction

  task automatic send_hsv(input logic [HUE_W-1:0] hue, input logic [FRAC_W-1:0] sat,
                          input logic [FRAC_W-1:0] val, input bit known, input rgb_t typed);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.hue_deg  <= hue;
    in_bus.sat_frac <= sat;
    in_bus.val_frac <= val;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    pending_rgb.push_back(known ? typed : hsv_to_rgb_expected(hue, sat, val));
  endtask

  task automatic send_random(input int count);
    logic [HUE_W-1:0]  hue;
    logic [FRAC_W-1:0] sat;
    logic [FRAC_W-1:0] val;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        // whole field range, clamps and hues past 359 included
        hue = HUE_W'($urandom);
        sat = FRAC_W'($urandom);
        val = FRAC_W'($urandom);
      end else begin
        hue = HUE_W'($urandom_range(0, 359));
        sat = ($urandom_range(0, 7) == 0) ? FRAC_W'($urandom_range(0, 1) ? FRAC_ONE : 0)
                                          : FRAC_W'($urandom_range(0, FRAC_ONE));
        val = ($urandom_range(0, 7) == 0) ? FRAC_W'($urandom_range(0, 1) ? FRAC_ONE : 0)
                                          : FRAC_W'($urandom_range(0, FRAC_ONE));
      end
      send_hsv(hue, sat, val, 1'b0, '0);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d transactions outstanding",
             cycle_count, pending_rgb.size());
    $display("** hsv_to_rgb_converter: FAILED **");
    $finish;
  end

  // result side: checks each transaction and drives ready with random stalls
  initial begin
    int   stall_left;
    int   hold_left;
    rgb_t want;
    stall_left = 0;
    hold_left  = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        if (pending_rgb.size() == 0) begin
          $display("%0t: unexpected result r=%0d g=%0d b=%0d", $time,
                   out_bus.red_out, out_bus.green_out, out_bus.blue_out);
          mismatch_count++;
        end else begin
          want = pending_rgb.pop_front();
          if (out_bus.red_out !== want.red) begin
            $display("%0t: red mismatch, expected %0d, actual %0d", $time,
                     want.red, out_bus.red_out);
            mismatch_count++;
          end
          if (out_bus.green_out !== want.green) begin
            $display("%0t: green mismatch, expected %0d, actual %0d", $time,
                     want.green, out_bus.green_out);
            mismatch_count++;
          end
          if (out_bus.blue_out !== want.blue) begin
            $display("%0t: blue mismatch, expected %0d, actual %0d", $time,
                     want.blue, out_bus.blue_out);
            mismatch_count++;
          end
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    mismatch_count = 0;
    idle_on  = 1'b1;
    hold_req = 1'b0;
    rst_n           <= 1'b0;
    in_bus.valid    <= 1'b0;
    in_bus.hue_deg  <= '0;
    in_bus.sat_frac <= '0;
    in_bus.val_frac <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_hsv(directed_rows[i].hue, directed_rows[i].sat, directed_rows[i].val,
               directed_rows[i].known, directed_rows[i].rgb);

    send_random(250);

    // sink holds off while transactions keep coming, so the pipeline backs up
    hold_req = 1'b1;
    send_random(100);

    // let the pipeline drain completely before carrying on
    in_bus.valid <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk);
    send_random(250);

    idle_on = 1'b0;
    send_random(200);
    in_bus.valid <= 1'b0;

    while (pending_rgb.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("** hsv_to_rgb_converter: PASSED **");
    else
      $display("** hsv_to_rgb_converter: FAILED **");
    $finish;
  end

endmodule

@@ hsv_to_rgb_converter.f @@
rtl/hsvc_pkg.sv
rtl/hsvc_if.sv
rtl/hsvc_split.sv
rtl/hsvc_coef.sv
rtl/hsvc_scale.sv
rtl/hsvc_mix.sv
rtl/hsv_to_rgb_converter.sv
tb/sv/tb_hsv_to_rgb_converter.sv
